// File: src/pcsc_pkg.sv
// Shared types, constants and codes for the per-client sequence checker.
package pcsc_pkg;

	// Table depth and entry index width
	localparam int MAX_CLIENTS = 16;
	localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;

	localparam logic [63:0] STALE_RESET = 64'd3000000000;

	// Configuration register indexes
	localparam logic [1:0] CFG_MAGIC   = 2'd0;
	localparam logic [1:0] CFG_VERSION = 2'd1;
	localparam logic [1:0] CFG_STALE   = 2'd2;

	typedef enum logic [1:0] {
		RSN_NONE      = 2'd0,
		RSN_BAD_MAGIC = 2'd1,
		RSN_VERSION   = 2'd2
	} reason_t;

	typedef enum logic [2:0] {
		CLS_NEXT         = 3'd0,
		CLS_NEW          = 3'd1,
		CLS_OUT_OF_ORDER = 3'd2,
		CLS_DUPLICATE    = 3'd3,
		CLS_GAP          = 3'd4,
		CLS_UNTRACKED    = 3'd5
	} seq_class_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_UPDATE
	} state_t;

	// Input beat
	typedef struct packed {
		logic [31:0] magic;
		logic [31:0] version;
		logic [63:0] client_id;
		logic [31:0] seq_num;
		logic [63:0] sent_time;
		logic [63:0] now_time;
		logic        has_command;
	} in_t;

	// Result beat
	typedef struct packed {
		logic        accepted;
		logic [1:0]  reject_reason;
		logic [2:0]  seq_class;
		logic        stale;
		logic [3:0]  slot;
		logic [63:0] last_heartbeat_time;
		logic [63:0] last_command_time;
	} out_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		logic        look;
		logic        commit;
		logic        any_hit;
		logic [63:0] key;
		logic [31:0] seq;
		logic [63:0] now;
		logic        has_cmd;
	} cell_ctrl_t;

	// Data handed from one cell to the next
	typedef struct packed {
		logic             free_seen;
		logic             hit_seen;
		logic [31:0]      hit_seq;
		logic [IDX_W-1:0] hit_idx;
		logic             claim_seen;
		logic [IDX_W-1:0] claim_idx;
	} chain_t;

endpackage

// File: src/per_client_sequence_checker.sv
// Top level: header check, client table row and result register.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one message header per beat.
//   Output channel (out_valid/out_ready/out_data) gives one result per header.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes expected
//   magic (0), expected version (1) and stale limit (2); cfg_ready is always
//   high. Write configuration only while no header is in flight.
// Timing:
//   A header passes through lookup, where every table cell compares its
//   key and the free-entry search ripples down the row, and then update,
//   where the row hands the matched entry forward and at most one cell writes.
//   The result is written to the output register as update completes; the
//   next header is taken only after the previous one has left update.
// Reset:
//   Clears all table entries, both global times and the config registers
//   (stale limit returns to 3000000000).
// Stalls:
//   A finished result waits in the output register; the next header is still
//   taken and held in update until the output register frees.
module per_client_sequence_checker
	import pcsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	state_t      state_q;
	state_t      state_nxt;
	logic [31:0] magic_cfg_q;
	logic [31:0] version_cfg_q;
	logic [63:0] stale_cfg_q;
	in_t         query_q;
	reason_t     reason_q;
	logic        stale_q;
	logic [63:0] gbl_heartbeat_q;
	logic [63:0] gbl_command_q;
	logic        out_valid_q;
	out_t        out_q;
	logic        look;
	logic        upd_fire;
	logic        commit;
	logic [63:0] age;
	logic [31:0] seq_diff;
	seq_class_t  cls;
	logic [3:0]  slot_sel;
	cell_ctrl_t  ctrl;
	chain_t      chain [MAX_CLIENTS+1];
	out_t        result;

	// Config writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_cfg_q   <= 32'd0;
			version_cfg_q <= 32'd0;
			stale_cfg_q   <= STALE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MAGIC:   magic_cfg_q   <= cfg_data[31:0];
				CFG_VERSION: version_cfg_q <= cfg_data[31:0];
				CFG_STALE:   stale_cfg_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer: next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_nxt = ST_LOOK;
			ST_LOOK:   state_nxt = ST_UPDATE;
			ST_UPDATE: if (!out_valid_q || out_ready) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// Sequencer: outputs
	always_comb begin
		in_ready = 1'b0;
		look     = 1'b0;
		upd_fire = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_LOOK:   look = 1'b1;
			ST_UPDATE: upd_fire = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Hold the accepted header
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			query_q <= in_data;
		end
	end

	// Header check and stale test during lookup
	assign age = query_q.now_time - query_q.sent_time;

	always_ff @(posedge clk) begin
		if (look) begin
			if (query_q.magic != magic_cfg_q) begin
				reason_q <= RSN_BAD_MAGIC;
			end else if (query_q.version != version_cfg_q) begin
				reason_q <= RSN_VERSION;
			end else begin
				reason_q <= RSN_NONE;
			end
			stale_q <= (query_q.now_time > query_q.sent_time) && (age > stale_cfg_q);
		end
	end

	// Broadcast to the cell row
	assign commit = upd_fire && (reason_q == RSN_NONE);

	always_comb begin
		ctrl.look    = look;
		ctrl.commit  = commit;
		ctrl.any_hit = chain[MAX_CLIENTS].hit_seen;
		ctrl.key     = query_q.client_id;
		ctrl.seq     = query_q.seq_num;
		ctrl.now     = query_q.now_time;
		ctrl.has_cmd = query_q.has_command;
	end

	assign chain[0] = '0;

	for (genvar i = 0; i < MAX_CLIENTS; i++) begin : g_cell
		pcsc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (IDX_W'(i)),
			.ctrl      (ctrl),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

	// Classify against the matched entry
	assign seq_diff = query_q.seq_num - chain[MAX_CLIENTS].hit_seq;

	always_comb begin
		cls      = CLS_UNTRACKED;
		slot_sel = 4'd0;
		if (chain[MAX_CLIENTS].hit_seen) begin
			slot_sel = 4'(chain[MAX_CLIENTS].hit_idx);
			if (query_q.seq_num < chain[MAX_CLIENTS].hit_seq) begin
				cls = CLS_OUT_OF_ORDER;
			end else if (seq_diff == 32'd0) begin
				cls = CLS_DUPLICATE;
			end else if (seq_diff > 32'd1) begin
				cls = CLS_GAP;
			end else begin
				cls = CLS_NEXT;
			end
		end else if (chain[MAX_CLIENTS].claim_seen) begin
			cls      = CLS_NEW;
			slot_sel = 4'(chain[MAX_CLIENTS].claim_idx);
		end
	end

	// Global times
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gbl_heartbeat_q <= 64'd0;
			gbl_command_q   <= 64'd0;
		end else if (commit) begin
			gbl_heartbeat_q <= query_q.now_time;
			if (query_q.has_command) begin
				gbl_command_q <= query_q.now_time;
			end
		end
	end

	// Assemble the result beat
	always_comb begin
		result.reject_reason       = reason_q;
		result.last_heartbeat_time = gbl_heartbeat_q;
		result.last_command_time   = gbl_command_q;
		if (reason_q == RSN_NONE) begin
			result.accepted            = 1'b1;
			result.seq_class           = cls;
			result.stale               = stale_q;
			result.slot                = slot_sel;
			result.last_heartbeat_time = query_q.now_time;
			if (query_q.has_command) begin
				result.last_command_time = query_q.now_time;
			end
		end else begin
			result.accepted  = 1'b0;
			result.seq_class = CLS_NEXT;
			result.stale     = 1'b0;
			result.slot      = 4'd0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: src/pcsc_cell.sv
// One client table entry with its match, free-slot and hand-off logic.
module pcsc_cell
	import pcsc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  cell_ctrl_t       ctrl,
	input  chain_t           chain_in,
	output chain_t           chain_out
);

	logic        valid_q;
	logic [63:0] key_q;
	logic [31:0] last_seq_q;
	logic [63:0] heartbeat_q;
	logic [63:0] command_q;
	logic        hit_q;
	logic        claim_q;
	logic        take;

	// Latch match and first-free decisions during lookup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			claim_q <= 1'b0;
		end else if (ctrl.look) begin
			hit_q   <= valid_q && (key_q == ctrl.key);
			claim_q <= !valid_q && !chain_in.free_seen;
		end
	end

	// Claim this entry only when no other entry holds the key
	assign take = ctrl.commit && (hit_q || (claim_q && !ctrl.any_hit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end
	end

	// Update entry contents on commit
	always_ff @(posedge clk) begin
		if (take) begin
			heartbeat_q <= ctrl.now;
			if (hit_q) begin
				last_seq_q <= ctrl.seq;
				if (ctrl.has_cmd) begin
					command_q <= ctrl.now;
				end
			end else begin
				key_q      <= ctrl.key;
				last_seq_q <= 32'd0;
				command_q  <= ctrl.has_cmd ? ctrl.now : 64'd0;
			end
		end
	end

	// Pass results down the row
	always_comb begin
		chain_out            = chain_in;
		chain_out.free_seen  = chain_in.free_seen | !valid_q;
		chain_out.hit_seen   = chain_in.hit_seen | hit_q;
		chain_out.hit_seq    = chain_in.hit_seq | (hit_q ? last_seq_q : 32'd0);
		chain_out.hit_idx    = chain_in.hit_idx | (hit_q ? idx : '0);
		chain_out.claim_seen = chain_in.claim_seen | claim_q;
		chain_out.claim_idx  = chain_in.claim_idx | (claim_q ? idx : '0);
	end

endmodule

// File: src/pcsc_checker.sv
// Port-level checks for the per-client sequence checker, bound to the top level.
module pcsc_checker
	import pcsc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat dropped or changed while stalled");

	// Drop input ready after a header is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready stayed high after accepting a header");

	// Reject carries a reason, accept carries none
	a_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.accepted == (out_data.reject_reason == RSN_NONE)))
		else $error("accepted flag disagrees with reject reason");

	// Rejected beats carry no class, slot or stale flag
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.accepted |->
			out_data.seq_class == CLS_NEXT && out_data.slot == 4'd0 && !out_data.stale)
		else $error("rejected beat carries table results");

endmodule

bind per_client_sequence_checker pcsc_checker u_pcsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// File: test/tb.sv
// Testbench for the per-client sequence checker: directed table, then random headers.
`timescale 1ns / 100ps

module tb;
	import pcsc_pkg::*;

	localparam logic [31:0] ALL32 = 32'hFFFF_FFFF;
	localparam logic [63:0] ALL64 = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int PHASE_ITEMS = 300;
	localparam int LONG_HOLD = 300;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_t         in_data;
	logic        out_valid;
	logic        out_ready;
	out_t        out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	// Mirror of the configuration registers
	logic [31:0] want_magic = '0;
	logic [31:0] want_version = '0;
	logic [63:0] stale_lim = STALE_RESET;

	// Mirror of the client table; per-client times never reach the result port
	bit          tbl_used [MAX_CLIENTS];
	logic [63:0] tbl_key [MAX_CLIENTS];
	logic [31:0] tbl_seq [MAX_CLIENTS];
	logic [63:0] glob_hb = '0;
	logic [63:0] glob_cmd = '0;

	out_t verdict_q [$];
	in_t  plan_msg [$];
	bit   plan_typed [$];
	out_t plan_want [$];

	int mismatches = 0;
	bit gaps_on = 1'b0;
	bit rx_hold_req = 1'b0;

	always #5 clk = ~clk;

	per_client_sequence_checker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	task note_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// Judge one header against the mirrored table and advance it
	function automatic out_t judge_header(input in_t m);
		out_t r;
		int hit;
		int free_idx;
		r = '0;
		hit = -1;
		free_idx = -1;
		if (m.magic != want_magic) begin
			r.reject_reason = RSN_BAD_MAGIC;
		end else if (m.version != want_version) begin
			r.reject_reason = RSN_VERSION;
		end else begin
			r.accepted = 1'b1;
			for (int i = 0; i < MAX_CLIENTS; i++) begin
				if (tbl_used[i] && tbl_key[i] == m.client_id) begin
					if (hit < 0) hit = i;
				end else if (!tbl_used[i] && free_idx < 0) begin
					free_idx = i;
				end
			end
			if (hit >= 0) begin
				if (m.seq_num < tbl_seq[hit]) r.seq_class = CLS_OUT_OF_ORDER;
				else if (m.seq_num == tbl_seq[hit]) r.seq_class = CLS_DUPLICATE;
				else if (m.seq_num - tbl_seq[hit] > 32'd1) r.seq_class = CLS_GAP;
				else r.seq_class = CLS_NEXT;
				tbl_seq[hit] = m.seq_num;
			end else if (free_idx >= 0) begin
				// new client: claim lowest free entry, last sequence starts at zero
				hit = free_idx;
				r.seq_class = CLS_NEW;
				tbl_used[hit] = 1'b1;
				tbl_key[hit] = m.client_id;
				tbl_seq[hit] = '0;
			end else begin
				r.seq_class = CLS_UNTRACKED;
			end
			r.stale = (m.now_time > m.sent_time) && (m.now_time - m.sent_time > stale_lim);
			glob_hb = m.now_time;
			if (m.has_command) glob_cmd = m.now_time;
			if (hit >= 0) r.slot = hit[3:0];
		end
		r.last_heartbeat_time = glob_hb;
		r.last_command_time = glob_cmd;
		return r;
	endfunction

	function automatic in_t hdr(input logic [31:0] mg, input logic [31:0] vr,
			input logic [63:0] id, input logic [31:0] sq, input logic [63:0] st,
			input logic [63:0] nw, input logic cmd);
		in_t m;
		m.magic = mg;
		m.version = vr;
		m.client_id = id;
		m.seq_num = sq;
		m.sent_time = st;
		m.now_time = nw;
		m.has_command = cmd;
		return m;
	endfunction

	function automatic out_t res(input logic acc, input reason_t rsn, input seq_class_t cls,
			input logic stl, input logic [3:0] sl, input logic [63:0] hb, input logic [63:0] cm);
		out_t r;
		r.accepted = acc;
		r.reject_reason = rsn;
		r.seq_class = cls;
		r.stale = stl;
		r.slot = sl;
		r.last_heartbeat_time = hb;
		r.last_command_time = cm;
		return r;
	endfunction

	task add_row(input in_t m, input bit typed, input out_t want);
		plan_msg.push_back(m);
		plan_typed.push_back(typed);
		plan_want.push_back(want);
	endtask

	// Random header: mostly known clients with plausible sequences, ages near the limit
	function automatic in_t make_header();
		in_t m;
		int pick;
		int k;
		logic [63:0] age;
		pick = $urandom_range(0, 99);
		m.magic = want_magic;
		m.version = want_version;
		m.client_id = {$urandom, $urandom};
		m.seq_num = $urandom;
		m.sent_time = {$urandom, $urandom};
		m.now_time = {$urandom, $urandom};
		m.has_command = 1'($urandom_range(0, 1));
		if (pick < 8) begin
			m.magic = $urandom;
			if (m.magic == want_magic) m.magic[0] = ~m.magic[0];
		end else if (pick < 14) begin
			m.version = $urandom;
			if (m.version == want_version) m.version[31] = ~m.version[31];
		end else begin
			// table is full after the directed part, so every entry is live
			if (pick < 86) begin
				k = $urandom_range(0, MAX_CLIENTS - 1);
				m.client_id = tbl_key[k];
				case ($urandom_range(0, 9))
					0, 1, 2, 3: m.seq_num = tbl_seq[k] + 32'd1;
					4: m.seq_num = tbl_seq[k];
					5: m.seq_num = tbl_seq[k] - $urandom_range(1, 1000);
					6, 7: m.seq_num = tbl_seq[k] + $urandom_range(2, 1000);
					default: ;
				endcase
			end
			age = '0;
			case ($urandom_range(0, 5))
				0: age = stale_lim;
				1: age = stale_lim + 64'd1;
				2: age = stale_lim - 64'd1;
				3: age = 64'($urandom_range(0, 5000));
				default: age = '0;
			endcase
			if (age != '0) m.sent_time = m.now_time - age;
		end
		return m;
	endfunction

	// Offer one header beat and record what it should produce
	task offer_header(input in_t m, input bit typed, input out_t typed_want);
		out_t v;
		in_data <= m;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		v = judge_header(m);
		verdict_q.push_back(typed ? typed_want : v);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Write all three registers, upper data bits of the 32-bit ones as noise
	task set_config(input logic [31:0] mg, input logic [31:0] vr, input logic [63:0] lim);
		logic [1:0] ri;
		logic [63:0] word;
		for (int i = 0; i < 3; i++) begin
			ri = (i == 0) ? CFG_MAGIC : (i == 1) ? CFG_VERSION : CFG_STALE;
			word = (ri == CFG_MAGIC) ? {$urandom, mg} : (ri == CFG_VERSION) ? {$urandom, vr} : lim;
			cfg_valid <= 1'b1;
			cfg_index <= ri;
			cfg_data <= word;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			case (ri)
				CFG_MAGIC: want_magic = mg;
				CFG_VERSION: want_version = vr;
				default: stale_lim = lim;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// Result side: random stalls, one long hold on request, compare each beat
	initial begin
		out_t w;
		int hold;
		hold = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					note_mismatch("result with no header pending", out_data.last_heartbeat_time, '0);
				end else begin
					w = verdict_q.pop_front();
					if (out_data.accepted !== w.accepted)
						note_mismatch("accepted", out_data.accepted, w.accepted);
					if (out_data.reject_reason !== w.reject_reason)
						note_mismatch("reject_reason", out_data.reject_reason, w.reject_reason);
					if (out_data.seq_class !== w.seq_class)
						note_mismatch("seq_class", out_data.seq_class, w.seq_class);
					if (out_data.stale !== w.stale)
						note_mismatch("stale", out_data.stale, w.stale);
					if (out_data.slot !== w.slot)
						note_mismatch("slot", out_data.slot, w.slot);
					if (out_data.last_heartbeat_time !== w.last_heartbeat_time)
						note_mismatch("last_heartbeat_time", out_data.last_heartbeat_time,
							w.last_heartbeat_time);
					if (out_data.last_command_time !== w.last_command_time)
						note_mismatch("last_command_time", out_data.last_command_time,
							w.last_command_time);
				end
			end
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold = LONG_HOLD;
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else if (gaps_on && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				hold = $urandom_range(0, 18);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Stimulus
	initial begin
		logic [63:0] id;
		logic [63:0] lim;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_MAGIC;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gaps_on = 1'b1;

		// Directed part, reset configuration: magic 0, version 0, default stale limit
		add_row(hdr(0, 0, 0, 5, 100, 200, 1), 1,
			res(1, RSN_NONE, CLS_NEW, 0, 0, 200, 200));
		add_row(hdr(0, 0, 0, 1, 300, 300, 0), 0, '0);
		add_row(hdr(0, 0, 0, 1, 400, 350, 1), 0, '0);
		add_row(hdr(0, 0, 0, 0, 0, 64'd3000000000, 0), 0, '0);
		add_row(hdr(0, 0, 0, ALL32, 0, 64'd3000000001, 0), 0, '0);
		add_row(hdr(ALL32, 0, 0, 7, 0, 9, 1), 1,
			res(0, RSN_BAD_MAGIC, CLS_NEXT, 0, 0, 64'd3000000001, 350));
		add_row(hdr(1, ALL32, ALL64, 7, 0, 9, 1), 1,
			res(0, RSN_BAD_MAGIC, CLS_NEXT, 0, 0, 64'd3000000001, 350));
		add_row(hdr(0, 32'h8000_0000, 0, 7, 0, 9, 1), 1,
			res(0, RSN_VERSION, CLS_NEXT, 0, 0, 64'd3000000001, 350));
		add_row(hdr(0, 0, ALL64, ALL32, 0, ALL64, 1), 1,
			res(1, RSN_NONE, CLS_NEW, 1, 1, ALL64, ALL64));
		add_row(hdr(0, 0, ALL64, 0, ALL64, 0, 0), 0, '0);
		// fill the remaining entries with distinct keys
		for (int i = 2; i < MAX_CLIENTS; i++) begin
			id = {$urandom, $urandom};
			id[7:0] = 8'(i);
			add_row(hdr(0, 0, id, $urandom, {$urandom, $urandom}, {$urandom, $urandom}, i[0]),
				0, '0);
		end
		// table full: new client goes untracked
		add_row(hdr(0, 0, 64'h5A5A_5A5A_5A5A_5A50, 3, 1000, 1000, 1), 1,
			res(1, RSN_NONE, CLS_UNTRACKED, 0, 0, 1000, 1000));
		for (int n = 0; n < plan_msg.size(); n++) begin
			offer_header(plan_msg[n], plan_typed[n], plan_want[n]);
		end

		// Random phases, each under its own configuration
		for (int ph = 0; ph < 6; ph++) begin
			in_valid <= 1'b0;
			while (verdict_q.size() != 0) @(posedge clk);
			lim = (ph == 2) ? STALE_RESET : (ph == 3) ? 64'($urandom) : {$urandom, $urandom};
			case (ph)
				0: set_config(ALL32, ALL32, '0);
				1: set_config('0, '0, ALL64);
				default: set_config($urandom, $urandom, lim);
			endcase
			gaps_on = (ph != 5);
			if (ph == 2) rx_hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				offer_header(make_header(), 1'b0, '0);
			end
		end

		// Drain and let the pipeline settle
		in_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
